[rtl/ubde_pkg.sv]
// Shared types, constants and helpers for the unwind body descriptor encoder.
package ubde_pkg;

   localparam int VALUE_W       = 64;
   localparam int DIGIT_W       = 7;
   localparam int MAX_LEB_BYTES = 10;
   localparam int LEB_LIMIT_W   = DIGIT_W * MAX_LEB_BYTES;

   // Action codes.
   localparam logic [1:0] ACT_EPILOGUE = 2'd0;
   localparam logic [1:0] ACT_LABEL    = 2'd1;
   localparam logic [1:0] ACT_COPY     = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_TIME = 2'd1;
   localparam logic [1:0] STATUS_LONG = 2'd2;

   // Header bytes.
   localparam logic [7:0] HDR_EPI_SHORT = 8'hC0;
   localparam logic [7:0] HDR_EPI_LONG  = 8'hE0;
   localparam logic [7:0] HDR_LABEL     = 8'h80;
   localparam logic [7:0] HDR_COPY      = 8'hA0;
   localparam logic [7:0] HDR_LABEL_X   = 8'hF0;
   localparam logic [7:0] HDR_COPY_X    = 8'hF8;

   localparam int SHORT_ARG_W = 5;

   typedef struct packed {
      logic load;
      logic shift;
   } ubde_shift_ctl_type;

   // True when the ULEB128 form of v needs more than MAX_LEB_BYTES bytes.
   function automatic logic uleb_too_long(input logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] rest;
      rest = v >> LEB_LIMIT_W;
      return |rest;
   endfunction

endpackage

[rtl/ubde_leb_shifter.sv]
// Digit shift register: loads a value and hands out one 7-bit ULEB128 group per cycle while ctl.shift is high.
module ubde_leb_shifter (
   input  logic                          clock,
   input  ubde_pkg::ubde_shift_ctl_type  ctl,
   input  logic [ubde_pkg::VALUE_W-1:0]  load_value,
   output logic [ubde_pkg::DIGIT_W-1:0]  digit,
   output logic                          more
);
   import ubde_pkg::*;

   logic [VALUE_W-1:0] val_ff;
   logic [VALUE_W-1:0] val_in;

   always_comb begin
      val_in = val_ff;
      if (ctl.load) begin
         val_in = load_value;
      end else if (ctl.shift) begin
         val_in = val_ff >> DIGIT_W;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign digit = val_ff[DIGIT_W-1:0];
   assign more  = |val_ff[VALUE_W-1:DIGIT_W];

endmodule

[rtl/unwind_body_descriptor_encoder.sv]
// Top level of the unwind body descriptor encoder: request latch, checks and byte sequencer.
//
// Each request (an epilogue, a state label or a state copy) turns into a byte
// stream on rsp_out_byte, one byte per cycle, with rsp_valid high for each
// byte and rsp_last_byte marking the final one. The receiver cannot stall:
// every byte is shown for exactly one cycle. A request is taken when start
// is high and busy is low. In the cycle after the transfer the request is
// checked (epilogue time against region_size, ULEB128 length limit) and the
// header byte is registered; the ULEB128 fields then follow one 7-bit group
// per cycle from a single digit shift register. busy stays high until the
// last byte of the item is registered; the longest epilogue has 21 bytes
// (header plus two ten-byte fields); an error gives one byte with status,
// and the unused action code gives no byte. region_size is written through
// the csr_ channel, which is always ready; write it only while busy is low
// and no byte is pending.
module unwind_body_descriptor_encoder (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic [ubde_pkg::VALUE_W-1:0]  req_when,
   input  logic [ubde_pkg::VALUE_W-1:0]  req_count_or_label,
   // result channel
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_byte,
   output logic [1:0]                    rsp_status,
   // configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ubde_pkg::VALUE_W-1:0]  csr_data
);
   import ubde_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_FIELD1,
      S_FIELD2
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [1:0]         action_ff, action_in;
   logic [VALUE_W-1:0] when_ff, when_in;
   logic [VALUE_W-1:0] arg_ff, arg_in;
   logic               two_fields_ff, two_fields_in;

   logic [VALUE_W-1:0] region_size_ff, region_size_in;

   // registered result
   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic [1:0]         status_ff, status_in;

   // shifter interface
   ubde_shift_ctl_type shift_ctl;
   logic [VALUE_W-1:0] shift_value;
   logic [DIGIT_W-1:0] digit;
   logic               more;

   logic accept;
   logic arg_short;
   logic time_bad;
   logic when_long;
   logic arg_long;

   assign accept    = start && (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign arg_short = ~|arg_ff[VALUE_W-1:SHORT_ARG_W];
   assign time_bad  = (when_ff >= region_size_ff);
   assign when_long = uleb_too_long(when_ff);
   assign arg_long  = uleb_too_long(arg_ff);

   ubde_leb_shifter u_shifter (
      .clock      (clock),
      .ctl        (shift_ctl),
      .load_value (shift_value),
      .digit      (digit),
      .more       (more)
   );

   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      when_in        = when_ff;
      arg_in         = arg_ff;
      two_fields_in  = two_fields_ff;
      region_size_in = region_size_ff;
      valid_in       = 1'b0;
      byte_in        = byte_ff;
      last_in        = last_ff;
      status_in      = status_ff;
      shift_ctl      = '0;
      shift_value    = arg_ff;

      if (csr_valid && csr_ready) begin
         region_size_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            // Capture the request on its transfer.
            if (accept) begin
               action_in = req_action;
               when_in   = req_when;
               arg_in    = req_count_or_label;
               state_in  = S_CHECK;
            end
         end

         S_CHECK: begin
            // Run all checks up front, then register the header byte and
            // load the first ULEB128 field, if the item has one, into the shifter.
            status_in = STATUS_OK;
            last_in   = 1'b0;
            state_in  = S_IDLE;
            case (action_ff)
               ACT_EPILOGUE: begin
                  valid_in = 1'b1;
                  if (time_bad) begin
                     byte_in   = 8'd0;
                     last_in   = 1'b1;
                     status_in = STATUS_TIME;
                  end else if (when_long || (!arg_short && arg_long)) begin
                     byte_in   = 8'd0;
                     last_in   = 1'b1;
                     status_in = STATUS_LONG;
                  end else begin
                     byte_in         = arg_short ? (HDR_EPI_SHORT | {3'd0, arg_ff[SHORT_ARG_W-1:0]})
                                                 : HDR_EPI_LONG;
                     two_fields_in   = !arg_short;
                     shift_ctl.load  = 1'b1;
                     shift_value     = when_ff;
                     state_in        = S_FIELD1;
                  end
               end

               ACT_LABEL, ACT_COPY: begin
                  valid_in = 1'b1;
                  if (arg_short) begin
                     byte_in = ((action_ff == ACT_LABEL) ? HDR_LABEL : HDR_COPY)
                               | {3'd0, arg_ff[SHORT_ARG_W-1:0]};
                     last_in = 1'b1;
                  end else if (arg_long) begin
                     byte_in   = 8'd0;
                     last_in   = 1'b1;
                     status_in = STATUS_LONG;
                  end else begin
                     byte_in        = (action_ff == ACT_LABEL) ? HDR_LABEL_X : HDR_COPY_X;
                     two_fields_in  = 1'b0;
                     shift_ctl.load = 1'b1;
                     shift_value    = arg_ff;
                     state_in       = S_FIELD1;
                  end
               end

               default: begin
                  // Unused action code: drop the request, emit nothing.
                  valid_in = 1'b0;
               end
            endcase
         end

         S_FIELD1, S_FIELD2: begin
            // Emit one 7-bit group per cycle, continuation bit on top.
            valid_in        = 1'b1;
            byte_in         = {more, digit};
            status_in       = STATUS_OK;
            last_in         = 1'b0;
            shift_ctl.shift = 1'b1;
            if (!more) begin
               if ((state_ff == S_FIELD1) && two_fields_ff) begin
                  shift_ctl.load = 1'b1;
                  shift_value    = arg_ff;
                  state_in       = S_FIELD2;
               end else begin
                  last_in  = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         valid_ff       <= 1'b0;
         region_size_ff <= '0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         region_size_ff <= region_size_in;
      end
      action_ff     <= action_in;
      when_ff       <= when_in;
      arg_ff        <= arg_in;
      two_fields_ff <= two_fields_in;
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;
   assign rsp_status    = status_ff;

endmodule
